/* design/adwl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adwl_pkg: shared constants and types for the audio delay with window level
// Sizes of the delay ring, the chunk-sum ring and the derived widths, plus
// the register index codes of the configuration port.
// ----------------------------------------------------------------------------
package adwl_pkg;

	localparam int CHANNELS     = 2;
	localparam int DELAY_DEPTH  = 131072;
	localparam int WINDOW_DEPTH = 256;

	localparam int FRAMES_MAX = 256;
	localparam int CHUNKS_MAX = 1024;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = 16;
	localparam int FRM_W    = 9;
	localparam int CHK_W    = 11;
	localparam int WREG_W   = 9;
	localparam int CFG_W    = 11;
	localparam int CIDX_W   = 2;
	localparam int LVL_W    = 33;

	localparam int CLEN_MAX = FRAMES_MAX * CHANNELS;
	localparam int CLEN_W   = $clog2(CLEN_MAX + 1);
	localparam int CPOS_W   = $clog2(CLEN_MAX);
	localparam int PROD_W   = CLEN_W + CHK_W;

	localparam int DADDR_W = $clog2(DELAY_DEPTH);
	localparam int DLEN_W  = $clog2(DELAY_DEPTH + 1);

	localparam int WADDR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int WCNT_W  = $clog2(WINDOW_DEPTH + 1);
	localparam int WCMP_W  = (WCNT_W > WREG_W) ? WCNT_W : WREG_W;

	localparam int ACC_W = $clog2(CLEN_MAX * 32768 + 1);
	localparam int TOT_W = LVL_W + 2;

	localparam logic [LVL_W-1:0] LEVEL_MAX = {LVL_W{1'b1}};

	localparam int RLEN_FULL = FRAMES_MAX * CHANNELS * 128;
	localparam int RLEN_RST  = (RLEN_FULL > DELAY_DEPTH) ? DELAY_DEPTH : RLEN_FULL;
	localparam int WIN_RST   = (16 > WINDOW_DEPTH) ? WINDOW_DEPTH : 16;

	typedef enum logic [CIDX_W-1:0] {
		CFG_CHUNK_FRAMES  = 2'd0,
		CFG_DELAY_CHUNKS  = 2'd1,
		CFG_WINDOW_CHUNKS = 2'd2
	} cfg_idx_t;

endpackage
`default_nettype wire

/* design/adwl_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adwl_ram: generic single-clock RAM
// One write port and one read port; registered, read-first read data that
// holds its value while the read enable is low.
// ----------------------------------------------------------------------------
module adwl_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

/* design/audio_delay_with_window_level.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// audio_delay_with_window_level: sample delay ring with moving window level
// Delays an interleaved sample stream by a configurable ring length and
// tracks the summed magnitude of the samples in a configurable window of chunks.
// ----------------------------------------------------------------------------
// Path: an accepted item's memory read data is registered in the memories
// and its result then in the output register.
// Throughput: one item per cycle while results are taken; each item does
// one read-first access to the delay memory and, at a chunk end, one to
// the chunk-sum memory. Reset: asynchronous, active low; the block needs
// no clearing pass and takes items as soon as reset is released.
// ----------------------------------------------------------------------------
module audio_delay_with_window_level (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [adwl_pkg::CIDX_W-1:0]           cfg_index,
	input  wire logic [adwl_pkg::CFG_W-1:0]            cfg_data,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic signed [adwl_pkg::SAMPLE_W-1:0]  sample_in,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic signed [adwl_pkg::SAMPLE_W-1:0]       delayed_sample,
	output logic [adwl_pkg::LVL_W-1:0]                 window_level,
	output logic                                       chunk_end
);

	// ------------------------------------------------------------------
	// Configuration. Registers are kept in their clamped, derived form:
	// the chunk length in samples, the ring length in samples (already
	// limited to the memory depth) and the window length in chunks. The
	// product for the ring length is formed on the write itself, so an
	// item right after a write already sees the new lengths.
	// ------------------------------------------------------------------
	logic [adwl_pkg::CLEN_W-1:0] clen_q;
	logic [adwl_pkg::CHK_W-1:0]  chunks_q;
	logic [adwl_pkg::DLEN_W-1:0] rlen_q;
	logic [adwl_pkg::WCNT_W-1:0] win_q;

	logic [adwl_pkg::FRM_W-1:0]  wr_frames;
	logic [adwl_pkg::CHK_W-1:0]  wr_chunks;
	logic [adwl_pkg::WCMP_W-1:0] wr_win;
	logic [adwl_pkg::CLEN_W-1:0] wr_clen;
	logic [adwl_pkg::PROD_W-1:0] ring_prod;
	logic [adwl_pkg::DLEN_W-1:0] ring_len;

	always_comb begin
		wr_frames = cfg_data[adwl_pkg::FRM_W-1:0];
		if (wr_frames == '0) begin
			wr_frames = adwl_pkg::FRM_W'(1);
		end else if (wr_frames > adwl_pkg::FRM_W'(adwl_pkg::FRAMES_MAX)) begin
			wr_frames = adwl_pkg::FRM_W'(adwl_pkg::FRAMES_MAX);
		end
		wr_clen = adwl_pkg::CLEN_W'(wr_frames) * adwl_pkg::CLEN_W'(adwl_pkg::CHANNELS);

		wr_chunks = cfg_data[adwl_pkg::CHK_W-1:0];
		if (wr_chunks == '0) begin
			wr_chunks = adwl_pkg::CHK_W'(1);
		end else if (wr_chunks > adwl_pkg::CHK_W'(adwl_pkg::CHUNKS_MAX)) begin
			wr_chunks = adwl_pkg::CHK_W'(adwl_pkg::CHUNKS_MAX);
		end

		wr_win = adwl_pkg::WCMP_W'(cfg_data[adwl_pkg::WREG_W-1:0]);
		if (wr_win == '0) begin
			wr_win = adwl_pkg::WCMP_W'(1);
		end else if (wr_win > adwl_pkg::WCMP_W'(adwl_pkg::WINDOW_DEPTH)) begin
			wr_win = adwl_pkg::WCMP_W'(adwl_pkg::WINDOW_DEPTH);
		end

		// The ring length follows whichever factor is being written.
		if (adwl_pkg::cfg_idx_t'(cfg_index) == adwl_pkg::CFG_CHUNK_FRAMES) begin
			ring_prod = adwl_pkg::PROD_W'(wr_clen) * adwl_pkg::PROD_W'(chunks_q);
		end else begin
			ring_prod = adwl_pkg::PROD_W'(clen_q) * adwl_pkg::PROD_W'(wr_chunks);
		end
		if (ring_prod > adwl_pkg::PROD_W'(adwl_pkg::DELAY_DEPTH)) begin
			ring_len = adwl_pkg::DLEN_W'(adwl_pkg::DELAY_DEPTH);
		end else begin
			ring_len = adwl_pkg::DLEN_W'(ring_prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clen_q   <= adwl_pkg::CLEN_W'(adwl_pkg::FRAMES_MAX * adwl_pkg::CHANNELS);
			chunks_q <= adwl_pkg::CHK_W'(128);
			rlen_q   <= adwl_pkg::DLEN_W'(adwl_pkg::RLEN_RST);
			win_q    <= adwl_pkg::WCNT_W'(adwl_pkg::WIN_RST);
		end else if (cfg_we) begin
			unique case (adwl_pkg::cfg_idx_t'(cfg_index))
				adwl_pkg::CFG_CHUNK_FRAMES: begin
					clen_q <= wr_clen;
					rlen_q <= ring_len;
				end
				adwl_pkg::CFG_DELAY_CHUNKS: begin
					chunks_q <= wr_chunks;
					rlen_q   <= ring_len;
				end
				adwl_pkg::CFG_WINDOW_CHUNKS: begin
					win_q <= adwl_pkg::WCNT_W'(wr_win);
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Handshake. Stage 1 holds an item whose memory reads are in flight;
	// stage 2 is the output register. Stage 1 moves on when the output
	// register is empty or being emptied, and a new item enters when stage
	// 1 is free or moving: one item a cycle while results are taken.
	// ------------------------------------------------------------------
	logic valid_s1;
	logic valid_s2;
	logic s2_free;
	logic move_s1;
	logic accept;

	assign s2_free  = !valid_s2 || out_ready;
	assign move_s1  = valid_s1 && s2_free;
	assign in_ready = !valid_s1 || s2_free;
	assign accept   = in_valid && in_ready;

	// ------------------------------------------------------------------
	// Accept stage: pointers, chunk accumulation and memory accesses.
	// Both memories are read-first, so the old entry is read and the new
	// value written at the same address in the same access; a following item at
	// the same address then reads the new value, with no forwarding.
	// ------------------------------------------------------------------
	logic [adwl_pkg::DADDR_W-1:0] dptr_q;
	logic [adwl_pkg::DLEN_W-1:0]  dfill_q;
	logic [adwl_pkg::CPOS_W-1:0]  cpos_q;
	logic [adwl_pkg::ACC_W-1:0]   acc_q;
	logic [adwl_pkg::WADDR_W-1:0] cptr_q;
	logic [adwl_pkg::WCNT_W-1:0]  cfill_q;

	logic [adwl_pkg::DADDR_W-1:0] dptr_cur;
	logic [adwl_pkg::DLEN_W-1:0]  dptr_inc;
	logic [adwl_pkg::DADDR_W-1:0] dptr_next;
	logic [adwl_pkg::CLEN_W-1:0]  cpos_inc;
	logic                         closes;
	logic [adwl_pkg::MAG_W-1:0]   mag;
	logic [adwl_pkg::ACC_W-1:0]   csum;
	logic [adwl_pkg::WADDR_W-1:0] cptr_cur;
	logic [adwl_pkg::WCNT_W-1:0]  cptr_inc;
	logic [adwl_pkg::WADDR_W-1:0] cptr_next;

	always_comb begin
		// A pointer left beyond a ring that was shortened restarts at zero.
		if (adwl_pkg::DLEN_W'(dptr_q) >= rlen_q) begin
			dptr_cur = '0;
		end else begin
			dptr_cur = dptr_q;
		end
		dptr_inc = adwl_pkg::DLEN_W'(dptr_cur) + adwl_pkg::DLEN_W'(1);
		if (dptr_inc >= rlen_q) begin
			dptr_next = '0;
		end else begin
			dptr_next = dptr_inc[adwl_pkg::DADDR_W-1:0];
		end

		cpos_inc = adwl_pkg::CLEN_W'(cpos_q) + adwl_pkg::CLEN_W'(1);
		closes   = (cpos_inc >= clen_q);

		// The most negative sample gives 0x8000, which is its magnitude.
		if (sample_in[adwl_pkg::SAMPLE_W-1]) begin
			mag = adwl_pkg::MAG_W'(~sample_in) + adwl_pkg::MAG_W'(1);
		end else begin
			mag = adwl_pkg::MAG_W'(sample_in);
		end
		csum = acc_q + adwl_pkg::ACC_W'(mag);

		if (adwl_pkg::WCNT_W'(cptr_q) >= win_q) begin
			cptr_cur = '0;
		end else begin
			cptr_cur = cptr_q;
		end
		cptr_inc = adwl_pkg::WCNT_W'(cptr_cur) + adwl_pkg::WCNT_W'(1);
		if (cptr_inc >= win_q) begin
			cptr_next = '0;
		end else begin
			cptr_next = cptr_inc[adwl_pkg::WADDR_W-1:0];
		end
	end

	// Both pointers only step by one from zero or return to zero, so the
	// written entries always form a prefix of each memory. The fill marks
	// record that prefix, and an entry beyond it reads as its reset zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dptr_q  <= '0;
			dfill_q <= '0;
			cpos_q  <= '0;
			acc_q   <= '0;
			cptr_q  <= '0;
			cfill_q <= '0;
		end else if (accept) begin
			dptr_q <= dptr_next;
			if (dptr_inc > dfill_q) begin
				dfill_q <= dptr_inc;
			end
			if (closes) begin
				cpos_q <= '0;
				acc_q  <= '0;
				cptr_q <= cptr_next;
				if (cptr_inc > cfill_q) begin
					cfill_q <= cptr_inc;
				end
			end else begin
				cpos_q <= cpos_inc[adwl_pkg::CPOS_W-1:0];
				acc_q  <= csum;
			end
		end
	end

	logic                       chunk_acc;
	logic [adwl_pkg::SAMPLE_W-1:0] delay_rdata;
	logic [adwl_pkg::ACC_W-1:0] csum_rdata;

	assign chunk_acc = accept && closes;

	adwl_ram #(
		.WIDTH (adwl_pkg::SAMPLE_W),
		.DEPTH (adwl_pkg::DELAY_DEPTH)
	) u_delay_ram (
		.clk   (clk),
		.we    (accept),
		.waddr (dptr_cur),
		.wdata (sample_in),
		.re    (accept),
		.raddr (dptr_cur),
		.rdata (delay_rdata)
	);

	adwl_ram #(
		.WIDTH (adwl_pkg::ACC_W),
		.DEPTH (adwl_pkg::WINDOW_DEPTH)
	) u_chunk_ram (
		.clk   (clk),
		.we    (chunk_acc),
		.waddr (cptr_cur),
		.wdata (csum),
		.re    (chunk_acc),
		.raddr (cptr_cur),
		.rdata (csum_rdata)
	);

	// ------------------------------------------------------------------
	// Stage 1: memory data is valid. The read data holds while the stage
	// stalls, because the memories are read only on an accepted item.
	// ------------------------------------------------------------------
	logic                       dhit_s1;
	logic                       end_s1;
	logic                       chit_s1;
	logic [adwl_pkg::ACC_W-1:0] cnew_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dhit_s1 <= (adwl_pkg::DLEN_W'(dptr_cur) < dfill_q);
			end_s1  <= closes;
			chit_s1 <= (adwl_pkg::WCNT_W'(cptr_cur) < cfill_q);
			cnew_s1 <= csum;
		end
	end

	// Window total: add the new chunk sum, drop the one it replaces, then
	// clamp at zero and at the top of the level range. Entries left from a
	// longer window can make the difference negative.
	logic [adwl_pkg::LVL_W-1:0] total_q;
	logic [adwl_pkg::ACC_W-1:0] cold;
	logic signed [adwl_pkg::TOT_W-1:0] tsum;
	logic [adwl_pkg::LVL_W-1:0] total_new;

	always_comb begin
		cold = chit_s1 ? csum_rdata : '0;
		tsum = $signed({2'b00, total_q})
			+ $signed(adwl_pkg::TOT_W'(cnew_s1))
			- $signed(adwl_pkg::TOT_W'(cold));
		if (tsum < 0) begin
			total_new = '0;
		end else if (tsum > $signed(adwl_pkg::TOT_W'(adwl_pkg::LEVEL_MAX))) begin
			total_new = adwl_pkg::LEVEL_MAX;
		end else begin
			total_new = tsum[adwl_pkg::LVL_W-1:0];
		end
		if (!end_s1) begin
			total_new = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
		end else if (move_s1) begin
			total_q <= total_new;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: output register.
	// ------------------------------------------------------------------
	logic [adwl_pkg::SAMPLE_W-1:0] delayed_s2;
	logic [adwl_pkg::LVL_W-1:0]    level_s2;
	logic                          end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (move_s1) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			delayed_s2 <= dhit_s1 ? delay_rdata : '0;
			level_s2   <= total_new;
			end_s2     <= end_s1;
		end
	end

	assign out_valid      = valid_s2;
	assign delayed_sample = delayed_s2;
	assign window_level   = level_s2;
	assign chunk_end      = end_s2;

endmodule
`default_nettype wire

/* design/adwl_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adwl_checker: port-level checks for the audio delay with window level
// Watches the handshakes and the level field over time; bound to the top.
// ----------------------------------------------------------------------------
module adwl_checker (
	input wire logic                                  clk,
	input wire logic                                  arst_n,
	input wire logic                                  in_valid,
	input wire logic                                  in_ready,
	input wire logic                                  out_valid,
	input wire logic                                  out_ready,
	input wire logic signed [adwl_pkg::SAMPLE_W-1:0]  delayed_sample,
	input wire logic [adwl_pkg::LVL_W-1:0]            window_level,
	input wire logic                                  chunk_end
);

	logic [1:0]                 pending_q;
	logic [adwl_pkg::LVL_W-1:0] last_level_q;
	logic                       in_acc;
	logic                       out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Items in flight, and the level that the last delivered result showed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= '0;
			last_level_q <= '0;
		end else begin
			if (in_acc && !out_acc) begin
				pending_q <= pending_q + 2'd1;
			end else if (!in_acc && out_acc) begin
				pending_q <= pending_q - 2'd1;
			end
			if (out_acc) begin
				last_level_q <= window_level;
			end
		end
	end

	// A stalled result holds still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(delayed_sample)
			&& $stable(window_level) && $stable(chunk_end))
		else $error("result changed while stalled");

	// No result without an item in flight.
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 2'd0)
		else $error("result without an accepted item");

	// At most two items are in flight: one awaiting memory data, one in the
	// output register.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q != 2'd3)
		else $error("more items in flight than stages");

	// The level changes only on a result that closes a chunk.
	a_level_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !chunk_end |-> window_level == last_level_q)
		else $error("level changed without a chunk end");

endmodule

bind audio_delay_with_window_level adwl_checker u_adwl_checker (.*);
`default_nettype wire

/* tb/audio_delay_with_window_level_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// audio_delay_with_window_level_test: regression bench for the delay ring
// Streams signed samples through the block under a series of register
// settings. A local copy of the delay ring and the chunk-sum window predicts
// every result, and each result is checked field by field as it leaves.
// ----------------------------------------------------------------------------
module audio_delay_with_window_level_test;

	import adwl_pkg::*;

	// One expected result: what the block should return for one accepted item.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] delayed;
		logic [LVL_W-1:0]           level;
		logic                       ended;
	} level_result_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [CIDX_W-1:0]          cfg_index;
	logic [CFG_W-1:0]           cfg_data;
	logic                       in_valid;
	logic                       in_ready;
	logic signed [SAMPLE_W-1:0] sample_in;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] delayed_sample;
	logic [LVL_W-1:0]           window_level;
	logic                       chunk_end;

	// Local copy of the configuration registers, as written (not yet clamped).
	logic [FRM_W-1:0]  frames_reg;
	logic [CHK_W-1:0]  chunks_reg;
	logic [WREG_W-1:0] window_reg;

	// Local copy of the block's state.
	logic signed [SAMPLE_W-1:0] delay_copy [DELAY_DEPTH];
	logic [DADDR_W-1:0]         delay_ptr;
	logic [CPOS_W-1:0]          chunk_pos;
	logic [ACC_W-1:0]           chunk_acc;
	logic [ACC_W-1:0]           sum_copy [WINDOW_DEPTH];
	logic [WADDR_W-1:0]         sum_ptr;
	logic [LVL_W-1:0]           level_total;

	level_result_t awaited_outputs[$];
	level_result_t head_result;
	int            failures = 0;

	// Chance, in percent, that the sender or the receiver idles in a cycle.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	audio_delay_with_window_level uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample_in     (sample_in),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.delayed_sample(delayed_sample),
		.window_level  (window_level),
		.chunk_end     (chunk_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// A register value of zero counts as one, and a value above the limit
	// counts as the limit.
	function automatic int effective_count(input int raw, input int hi);
		if (raw == 0)
			return 1;
		if (raw > hi)
			return hi;
		return raw;
	endfunction

	// Advances the local copy by one accepted sample and queues the result
	// that the block must return for it.
	task automatic advance_delay_and_level(input logic signed [SAMPLE_W-1:0] smp);
		int            frames;
		int            chunks;
		int            win;
		int            clen;
		int            rlen;
		logic [MAG_W-1:0] mag;
		longint        total_next;
		level_result_t res;
		frames = effective_count(frames_reg, FRAMES_MAX);
		chunks = effective_count(chunks_reg, CHUNKS_MAX);
		win    = effective_count(window_reg, WINDOW_DEPTH);
		clen   = frames * CHANNELS;
		rlen   = clen * chunks;
		if (rlen > DELAY_DEPTH)
			rlen = DELAY_DEPTH;

		// A pointer left beyond a ring that has since shrunk restarts at entry 0.
		if (delay_ptr >= rlen)
			delay_ptr = '0;
		res.delayed = delay_copy[delay_ptr];
		delay_copy[delay_ptr] = smp;
		if (delay_ptr + 1 >= rlen)
			delay_ptr = '0;
		else
			delay_ptr = delay_ptr + 1'b1;

		// The most negative sample has magnitude 32768, which still fits.
		mag = smp[SAMPLE_W-1] ? (~smp + 1'b1) : smp;
		chunk_acc = chunk_acc + mag;
		if (chunk_pos + 1 >= clen) begin
			if (sum_ptr >= win)
				sum_ptr = '0;
			total_next = longint'(level_total) + longint'(chunk_acc)
				- longint'(sum_copy[sum_ptr]);
			sum_copy[sum_ptr] = chunk_acc;
			if (total_next < 0)
				total_next = 0;
			else if (total_next > longint'(LEVEL_MAX))
				total_next = longint'(LEVEL_MAX);
			level_total = total_next[LVL_W-1:0];
			if (sum_ptr + 1 >= win)
				sum_ptr = '0;
			else
				sum_ptr = sum_ptr + 1'b1;
			chunk_acc = '0;
			chunk_pos = '0;
			res.ended = 1'b1;
		end else begin
			chunk_pos = chunk_pos + 1'b1;
			res.ended = 1'b0;
		end
		res.level = level_total;
		awaited_outputs.push_back(res);
	endtask

	// Mostly full-range random samples, with the extremes, zero and values
	// near zero mixed in.
	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'sh0000;
			3: return 16'($urandom_range(0, 16)) - 16'sd8;
			default: return 16'($urandom);
		endcase
	endfunction

	// Presents one item and holds it until the block takes it. The call starts
	// and ends at a falling edge; valid stays high on return so that the next
	// item can follow without a gap.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid  = 1'b1;
		sample_in = smp;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		advance_delay_and_level(smp);
		@(negedge clk);
	endtask

	// Drives one register write; the caller lowers the write enable.
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		case (idx)
			CFG_CHUNK_FRAMES:  frames_reg = data[FRM_W-1:0];
			CFG_DELAY_CHUNKS:  chunks_reg = data[CHK_W-1:0];
			CFG_WINDOW_CHUNKS: window_reg = data[WREG_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Waits until every result has come out, then rewrites all three
	// registers. Every item yields a result, so an empty queue means the
	// block is idle.
	task automatic apply_settings(input logic [CFG_W-1:0] frames,
			input logic [CFG_W-1:0] chunks, input logic [CFG_W-1:0] window);
		in_valid = 1'b0;
		while (awaited_outputs.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		write_register(CFG_CHUNK_FRAMES, frames);
		write_register(CFG_DELAY_CHUNKS, chunks);
		write_register(CFG_WINDOW_CHUNKS, window);
		cfg_we = 1'b0;
	endtask

	// Values straight after reset: a 65536-sample ring and 512-sample chunks,
	// fed with the extremes of the sample range.
	task automatic test_reset_config();
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sh0000);
		send_sample(-16'sd1);
	endtask

	// All registers zero act as one: two-sample chunks, a two-sample ring and
	// a one-chunk window. The delay pointer left from reset restarts at entry
	// zero, and the chunk left open from reset closes on the first sample.
	task automatic test_zero_registers();
		apply_settings(11'd0, 11'd0, 11'd0);
		send_sample(16'sh7FFF);
		send_sample(16'sh8000);
		send_sample(16'sd1);
		send_sample(-16'sd1);
		send_sample(16'sh5555);
		send_sample(16'shAAAA);
		send_sample(16'sh0000);
		send_sample(16'sh8000);
	endtask

	// All bits set: frame and window bits above nine are dropped, then every
	// count saturates and the ring length is capped by the store depth.
	task automatic test_oversized_registers();
		apply_settings(11'h7FF, 11'h7FF, 11'h7FF);
		repeat (6) send_sample(random_sample());
	endtask

	// The exact upper limits of all three registers.
	task automatic test_exact_maxima();
		apply_settings(11'd256, 11'd1024, 11'd256);
		repeat (3) send_sample(random_sample());
	endtask

	// Short rings and small windows, so that the delay wraps and the window
	// turns over many times per setting. The unused upper bits of the two
	// narrow registers carry junk that the block must ignore.
	task automatic test_short_rings();
		logic [CFG_W-1:0] frames_data;
		logic [CFG_W-1:0] chunks_data;
		logic [CFG_W-1:0] window_data;
		repeat (5) begin
			frames_data = ($urandom_range(0, 4) == 0) ? '0 : CFG_W'($urandom_range(1, 4));
			chunks_data = ($urandom_range(0, 4) == 0) ? '0 : CFG_W'($urandom_range(1, 6));
			window_data = ($urandom_range(0, 4) == 0) ? '0 : CFG_W'($urandom_range(1, 8));
			frames_data[CFG_W-1:FRM_W]  = 2'($urandom_range(0, 3));
			window_data[CFG_W-1:WREG_W] = 2'($urandom_range(0, 3));
			apply_settings(frames_data, chunks_data, window_data);
			repeat (24) send_sample(random_sample());
		end
	endtask

	// The longest chunk with a one-chunk delay: a full chunk closes once and
	// the 512-sample ring wraps near the end of the run.
	task automatic test_longest_chunk();
		apply_settings(11'd256, 11'd1, 11'd2);
		repeat (520) send_sample(random_sample());
	endtask

	// The widest window with two-sample chunks, so that every one of the 256
	// chunk sums is written and the oldest starts to be replaced.
	task automatic test_widest_window();
		apply_settings(11'd1, 11'd3, 11'd256);
		repeat (530) send_sample(random_sample());
	endtask

	// The receiver decides at each falling edge whether it takes a result at
	// the next rising edge.
	always @(negedge clk)
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	// Every result taken is compared with the oldest expected result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (awaited_outputs.size() == 0) begin
				$display("%0t: result with none expected, got delayed %0d level %0d end %0b",
					$time, delayed_sample, window_level, chunk_end);
				failures++;
			end else begin
				head_result = awaited_outputs.pop_front();
				if (delayed_sample !== head_result.delayed) begin
					$display("%0t: delayed_sample expected %0d, got %0d",
						$time, head_result.delayed, delayed_sample);
					failures++;
				end
				if (window_level !== head_result.level) begin
					$display("%0t: window_level expected %0d, got %0d",
						$time, head_result.level, window_level);
					failures++;
				end
				if (chunk_end !== head_result.ended) begin
					$display("%0t: chunk_end expected %0b, got %0b",
						$time, head_result.ended, chunk_end);
					failures++;
				end
			end
		end
	end

	initial begin
		int guard;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_CHUNK_FRAMES;
		cfg_data  = '0;
		in_valid  = 1'b0;
		sample_in = '0;

		// The local copy starts from the reset state of the block.
		frames_reg  = FRM_W'(FRAMES_MAX);
		chunks_reg  = CHK_W'(128);
		window_reg  = WREG_W'(16);
		delay_ptr   = '0;
		chunk_pos   = '0;
		chunk_acc   = '0;
		sum_ptr     = '0;
		level_total = '0;
		for (int i = 0; i < DELAY_DEPTH; i++)
			delay_copy[i] = '0;
		for (int i = 0; i < WINDOW_DEPTH; i++)
			sum_copy[i] = '0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// First third: the receiver stalls heavily, the sender rarely.
		send_idle_pct = 6;
		recv_idle_pct = 85;
		test_reset_config();
		test_zero_registers();
		test_oversized_registers();
		test_exact_maxima();
		test_short_rings();
		test_longest_chunk();

		// Second third: the sender leaves long gaps instead.
		send_idle_pct = 85;
		recv_idle_pct = 6;
		test_short_rings();
		test_widest_window();

		// Last part: both sides run flat out.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_short_rings();

		// Drain what is still in flight, then keep the clock running so that any
		// extra result from the output stage would show up.
		in_valid = 1'b0;
		guard = 0;
		while (awaited_outputs.size() != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		repeat (8) @(negedge clk);
		if (awaited_outputs.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				awaited_outputs.size());
			failures++;
		end
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// A time bound far beyond the slowest correct run.
	initial begin
		#5000000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
`default_nettype wire

/* filelist.f */
design/adwl_pkg.sv
design/adwl_ram.sv
design/audio_delay_with_window_level.sv
design/adwl_checker.sv
tb/audio_delay_with_window_level_test.sv
